[src/ccc_pkg.sv]
// Shared types, character codes and helpers for the code completeness checker.
package ccc_pkg;

   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_LSQUARE   = 8'h5B;
   localparam logic [7:0] CH_RSQUARE   = 8'h5D;
   localparam logic [7:0] CH_LCURLY    = 8'h7B;
   localparam logic [7:0] CH_RCURLY    = 8'h7D;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_PAREN  = 2'd1,
      KIND_SQUARE = 2'd2,
      KIND_CURLY  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_COMPLETE   = 2'd0,
      STATUS_INCOMPLETE = 2'd1,
      STATUS_INVALID    = 2'd2,
      STATUS_OVERFLOW   = 2'd3
   } status_type;

   // operation broadcast to every stack cell
   typedef struct packed {
      logic     push;
      logic     pop;
      logic     clear;
      kind_type kind;
   } stack_op_type;

   // what the scanner needs to know about the stack
   typedef struct packed {
      kind_type top_kind;
      logic     empty;
      logic     one;
      logic     full;
   } stack_info_type;

   function automatic kind_type kind_of(input logic [7:0] c);
      kind_type k;
      k = KIND_NONE;
      if (c == CH_LPAREN || c == CH_RPAREN) k = KIND_PAREN;
      if (c == CH_LSQUARE || c == CH_RSQUARE) k = KIND_SQUARE;
      if (c == CH_LCURLY || c == CH_RCURLY) k = KIND_CURLY;
      return k;
   endfunction

endpackage

[src/ccc_stack_cell.sv]
// One entry of the shifting bracket stack.
module ccc_stack_cell
   import ccc_pkg::*;
(
   input  logic         clock,
   input  stack_op_type op,
   input  kind_type     from_above,
   input  kind_type     from_below,
   output kind_type     kind
);

   kind_type kind_ff;
   kind_type kind_in;

   always_comb begin
      kind_in = kind_ff;
      if (op.push) begin
         kind_in = from_above;
      end else if (op.pop) begin
         kind_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

[src/ccc_stack.sv]
// Bracket stack built as a row of shifting cells; top of stack sits in cell 0.
module ccc_stack
   import ccc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  stack_op_type   op,
   output stack_info_type info
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   kind_type         cell_kind [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      kind_type above;
      kind_type below;
      if (i == 0) begin : g_head
         assign above = op.kind;
      end else begin : g_mid
         assign above = cell_kind[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign below = KIND_NONE;
      end else begin : g_body
         assign below = cell_kind[i+1];
      end
      ccc_stack_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_above (above),
         .from_below (below),
         .kind       (cell_kind[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op.clear) begin
         count_in = '0;
      end else if (op.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      info.empty    = (count_ff == '0);
      info.one      = (count_ff == CNT_W'(1));
      info.full     = (count_ff == CNT_W'(STACK_DEPTH));
      info.top_kind = info.empty ? KIND_NONE : cell_kind[0];
   end

endmodule

[src/ccc_scanner.sv]
// Scanner modes (quotes, comments, escapes, sticky errors) and final status.
module ccc_scanner
   import ccc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           beat,
   input  logic           last,
   input  logic           scan_en,
   input  logic [7:0]     cur_byte,
   input  logic [7:0]     next_byte,
   input  stack_info_type stack_info,
   output stack_op_type   stack_op,
   output status_type     status
);

   logic sq_ff, dq_ff, lc_ff, bc_ff, esc_ff, skip_ff, inv_ff, ovf_ff;
   logic sq_in, dq_in, lc_in, bc_in, esc_in, skip_in, inv_in, ovf_in;
   logic push, pop, stop, open_after;
   kind_type ck;

   always_comb begin
      sq_in   = sq_ff;
      dq_in   = dq_ff;
      lc_in   = lc_ff;
      bc_in   = bc_ff;
      esc_in  = esc_ff;
      skip_in = skip_ff;
      inv_in  = inv_ff;
      ovf_in  = ovf_ff;
      push    = 1'b0;
      pop     = 1'b0;
      stop    = 1'b0;
      ck      = kind_of(cur_byte);
      if (!scan_en || inv_ff || ovf_ff) begin
         stop = 1'b1;
      end else if (esc_ff) begin
         esc_in = 1'b0;
         stop   = 1'b1;
      end else if (skip_ff) begin
         skip_in = 1'b0;
         stop    = 1'b1;
      end else if (sq_ff || dq_ff) begin
         if (cur_byte == CH_BACKSLASH) esc_in = 1'b1;
         if (cur_byte == CH_NEWLINE) begin
            inv_in = 1'b1;
            stop   = 1'b1;
         end else if (cur_byte != (sq_ff ? CH_SQUOTE : CH_DQUOTE)) begin
            stop = 1'b1;
         end
      end
      if (!stop) begin
         if (lc_ff) begin
            if (cur_byte == CH_NEWLINE) lc_in = 1'b0;
         end else if (bc_ff) begin
            if (cur_byte == CH_STAR && next_byte == CH_SLASH) begin
               bc_in   = 1'b0;
               skip_in = 1'b1;
            end
         end else if (cur_byte == CH_LPAREN || cur_byte == CH_LSQUARE ||
                      cur_byte == CH_LCURLY) begin
            if (stack_info.full) begin
               ovf_in = 1'b1;
            end else begin
               push = 1'b1;
            end
         end else if (cur_byte == CH_RPAREN || cur_byte == CH_RSQUARE ||
                      cur_byte == CH_RCURLY) begin
            pop = !stack_info.empty;
            if (stack_info.top_kind != ck) inv_in = 1'b1;
         end else if (cur_byte == CH_SQUOTE) begin
            sq_in = !sq_ff;
         end else if (cur_byte == CH_DQUOTE) begin
            dq_in = !dq_ff;
         end else if (cur_byte == CH_SLASH) begin
            if (next_byte == CH_SLASH) begin
               lc_in = 1'b1;
            end else if (next_byte == CH_STAR) begin
               bc_in   = 1'b1;
               skip_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      stack_op.push  = beat && push;
      stack_op.pop   = beat && pop;
      stack_op.clear = beat && last;
      stack_op.kind  = ck;
   end

   // brackets still open once this byte is scanned
   assign open_after = push || (!stack_info.empty && !(stack_info.one && pop));

   always_comb begin
      if (inv_in) begin
         status = STATUS_INVALID;
      end else if (ovf_in) begin
         status = STATUS_OVERFLOW;
      end else if (sq_in || dq_in || lc_in || bc_in || open_after) begin
         status = STATUS_INCOMPLETE;
      end else if (scan_en && cur_byte == CH_BACKSLASH) begin
         status = STATUS_INCOMPLETE;
      end else begin
         status = STATUS_COMPLETE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (beat && last)) begin
         sq_ff   <= 1'b0;
         dq_ff   <= 1'b0;
         lc_ff   <= 1'b0;
         bc_ff   <= 1'b0;
         esc_ff  <= 1'b0;
         skip_ff <= 1'b0;
         inv_ff  <= 1'b0;
         ovf_ff  <= 1'b0;
      end else if (beat) begin
         sq_ff   <= sq_in;
         dq_ff   <= dq_in;
         lc_ff   <= lc_in;
         bc_ff   <= bc_in;
         esc_ff  <= esc_in;
         skip_ff <= skip_in;
         inv_ff  <= inv_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

[src/code_completeness_checker_unit.sv]
// Top level of the C source completeness checker.
// Source bytes stream in one beat per cycle, with tlast on the final byte of a
// buffer. Each byte is scanned one beat late, with the following byte as
// lookahead, so the final byte only serves as lookahead. The bracket stack is
// a row of STACK_DEPTH cells that shift together on push and pop, so a new
// beat is taken every cycle while the result register is empty or being
// drained. On the tlast beat one status beat is produced (0 complete,
// 1 incomplete, 2 invalid, 3 stack overflow) and all state clears for the next
// buffer; no clearing pass is needed after reset.
module code_completeness_checker_unit
   import ccc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] status, [7:2] zero
);

   logic           beat;
   logic [7:0]     held_ff;
   logic           held_valid_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   status_type     rsp_status_ff;
   status_type     status;
   stack_op_type   stack_op;
   stack_info_type stack_info;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat       = req_tvalid && req_tready;

   ccc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .op    (stack_op),
      .info  (stack_info)
   );

   ccc_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .last       (req_tlast),
      .scan_en    (held_valid_ff),
      .cur_byte   (held_ff),
      .next_byte  (req_tdata),
      .stack_info (stack_info),
      .stack_op   (stack_op),
      .status     (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (beat) begin
         held_valid_ff <= !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         held_ff <= req_tdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (beat && req_tlast) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat && req_tlast) begin
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff};

endmodule
